// File: rtl/clrf_pkg.sv
// shared types and constants for the coprocessor link register block
// no dependencies; imported by clrf_fifo_mem, clrf_ctrl and the top level
package clrf_pkg;

  // access modes
  localparam logic [1:0] MODE_HOST_RD  = 2'd0;
  localparam logic [1:0] MODE_HOST_WR  = 2'd1;
  localparam logic [1:0] MODE_COPRO_RD = 2'd2;
  localparam logic [1:0] MODE_COPRO_WR = 2'd3;

  // register map, even is status and odd is data
  localparam logic [2:0] REG_CH1_ST = 3'd0;
  localparam logic [2:0] REG_CH1_DT = 3'd1;
  localparam logic [2:0] REG_CH2_ST = 3'd2;
  localparam logic [2:0] REG_CH2_DT = 3'd3;
  localparam logic [2:0] REG_CH3_ST = 3'd4;
  localparam logic [2:0] REG_CH3_DT = 3'd5;
  localparam logic [2:0] REG_CH4_ST = 3'd6;
  localparam logic [2:0] REG_CH4_DT = 3'd7;

  // configuration register indexes
  localparam logic CFG_LINK_EN  = 1'b0;
  localparam logic CFG_DIS_RVAL = 1'b1;

  localparam logic       LINK_EN_RST  = 1'b1;
  localparam logic [7:0] DIS_RVAL_RST = 8'hfe;

  // per-channel status pair bits
  localparam int ST_NF = 0;
  localparam int ST_AV = 1;
  localparam logic [1:0] ST_RST_NF   = 2'b01;
  localparam logic [1:0] ST_RST_AVNF = 2'b11;

  // control flag bits
  localparam int FL_Q = 0;
  localparam int FL_I = 1;
  localparam int FL_J = 2;
  localparam int FL_M = 3;
  localparam int FL_V = 4;
  localparam int FL_P = 5;

  // flag register write control bits
  localparam int FW_SET = 7;
  localparam int FW_RST = 6;

  typedef struct packed {
    logic [1:0] mode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       host_irq;
    logic       copro_irq;
    logic       copro_nmi;
    logic       copro_reset;
  } out_item_t;

  // result of one access before the fifo read data joins it
  typedef struct packed {
    logic [7:0] rd_byte;
    logic       use_fifo;
    logic       host_irq;
    logic       copro_irq;
    logic       copro_nmi;
    logic       copro_reset;
  } stage_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } fifo_ctl_t;

  function automatic logic [7:0] status_byte(logic [1:0] st, logic [5:0] flags);
    return {st[ST_AV], st[ST_NF], flags};
  endfunction

endpackage

// File: rtl/clrf_fifo_mem.sv
// storage for the channel 1 upward fifo: synchronous ram with registered read data
// per-entry valid flags make unwritten entries read as zero; uses clrf_pkg
module clrf_fifo_mem import clrf_pkg::*; #(
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fifo_ctl_t                ctl,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [7:0]               wr_data,
  output logic [7:0]               rd_data
);

  logic [7:0]       mem_r [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [7:0]       rdq_r;
  logic             rdv_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rdq_r <= mem_r[rd_addr];
      rdv_r <= vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      vld_r <= '0;
    end else if (ctl.wr_en) begin
      vld_r[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rdv_r ? rdq_r : 8'h00;

endmodule

// File: rtl/clrf_ctrl.sv
// channel state, access decode and interrupt levels of the coprocessor link
// drives the fifo ram commands; uses clrf_pkg
module clrf_ctrl import clrf_pkg::*; #(
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     acc,
  input  in_item_t                 item,
  input  logic                     link_en,
  input  logic [7:0]               dis_rval,
  output stage_t                   res,
  output fifo_ctl_t                fctl,
  output logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [$clog2(DEPTH)-1:0] wr_addr,
  output logic [7:0]               wr_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  typedef struct packed {
    logic [7:0] p0;
    logic [7:0] p1;
    logic [1:0] cnt;
    logic       evt;
  } c3_t;

  function automatic c3_t c3_write(c3_t c, logic two, logic [7:0] d);
    c3_t n;
    n = c;
    n.evt = 1'b0;
    if (two) begin
      if (c.cnt < 2'd2) begin
        if (c.cnt == 2'd0) n.p0 = d;
        else n.p1 = d;
        n.cnt = c.cnt + 2'd1;
      end
      n.evt = (n.cnt == 2'd2);
    end else begin
      n.p0  = d;
      n.cnt = 2'd1;
      n.evt = 1'b1;
    end
    return n;
  endfunction

  function automatic c3_t c3_read(c3_t c);
    c3_t n;
    n = c;
    n.evt = 1'b0;
    if (c.cnt != 2'd0) begin
      n.p0  = c.p1;
      n.cnt = c.cnt - 2'd1;
      n.evt = (n.cnt == 2'd0);
    end
    return n;
  endfunction

  logic [5:0]      flags_r, flags_nxt;
  logic [CW-1:0]   ucnt_r, ucnt_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [7:0]      last_r, last_nxt;
  logic [7:0]      ch1d_r, ch1d_nxt;
  logic [7:0]      ch2u_r, ch2u_nxt;
  logic [7:0]      ch2d_r, ch2d_nxt;
  logic [7:0]      ch4u_r, ch4u_nxt;
  logic [7:0]      ch4d_r, ch4d_nxt;
  c3_t             up3_r, up3_nxt;
  c3_t             dn3_r, dn3_nxt;
  logic [3:0][1:0] hst_r, hst_nxt;
  logic [3:0][1:0] cst_r, cst_nxt;

  c3_t             c3_tmp;
  logic [SW-1:0]   tail_sum;
  logic [SW-1:0]   tail_wrap;
  logic            wr_req;
  logic            clr_req;
  logic            nmi_cond;
  logic [7:0]      d;

  assign d         = item.write_data;
  assign tail_sum  = SW'(head_r) + SW'(ucnt_r);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;

  always_comb begin
    flags_nxt = flags_r;
    ucnt_nxt  = ucnt_r;
    head_nxt  = head_r;
    last_nxt  = last_r;
    ch1d_nxt  = ch1d_r;
    ch2u_nxt  = ch2u_r;
    ch2d_nxt  = ch2d_r;
    ch4u_nxt  = ch4u_r;
    ch4d_nxt  = ch4d_r;
    up3_nxt   = up3_r;
    dn3_nxt   = dn3_r;
    hst_nxt   = hst_r;
    cst_nxt   = cst_r;
    c3_tmp    = '0;
    wr_req    = 1'b0;
    clr_req   = 1'b0;
    wr_addr   = head_r;
    wr_data   = last_r;
    res.rd_byte  = 8'h00;
    res.use_fifo = 1'b0;

    unique case (item.mode)
      MODE_HOST_RD: begin
        if (!link_en) begin
          res.rd_byte = dis_rval;
        end else begin
          unique case (item.reg_index)
            REG_CH1_ST: res.rd_byte = status_byte(hst_r[0], flags_r);
            REG_CH1_DT: begin
              res.use_fifo = 1'b1;
              if (ucnt_r != '0) begin
                // shift: the vacated tail slot keeps the old last entry
                wr_req   = 1'b1;
                wr_addr  = head_r;
                wr_data  = last_r;
                head_nxt = (head_r == PW'(DEPTH - 1)) ? '0 : head_r + PW'(1);
                ucnt_nxt = ucnt_r - CW'(1);
                if (ucnt_r == CW'(1)) hst_nxt[0][ST_AV] = 1'b0;
                cst_nxt[0][ST_NF] = 1'b1;
              end
            end
            REG_CH2_ST: res.rd_byte = status_byte(hst_r[1], 6'h00);
            REG_CH2_DT: begin
              res.rd_byte = ch2u_r;
              if (hst_r[1][ST_AV]) begin
                hst_nxt[1][ST_AV] = 1'b0;
                cst_nxt[1][ST_NF] = 1'b1;
              end
            end
            REG_CH3_ST: res.rd_byte = status_byte(hst_r[2], 6'h00);
            REG_CH3_DT: begin
              res.rd_byte = up3_r.p0;
              c3_tmp  = c3_read(up3_r);
              up3_nxt = c3_tmp;
              if (c3_tmp.evt) begin
                hst_nxt[2][ST_AV] = 1'b0;
                cst_nxt[2][ST_NF] = 1'b1;
              end
            end
            REG_CH4_ST: res.rd_byte = status_byte(hst_r[3], 6'h00);
            REG_CH4_DT: begin
              res.rd_byte = ch4u_r;
              if (hst_r[3][ST_AV]) begin
                hst_nxt[3][ST_AV] = 1'b0;
                cst_nxt[3][ST_NF] = 1'b1;
              end
            end
          endcase
        end
      end

      MODE_HOST_WR: begin
        if (link_en) begin
          unique case (item.reg_index)
            REG_CH1_ST: begin
              if (d[FW_SET]) begin
                flags_nxt = flags_r | d[5:0];
                if (d[FW_RST]) begin
                  // channel reset, flags stay
                  clr_req  = 1'b1;
                  ucnt_nxt = '0;
                  head_nxt = '0;
                  last_nxt = 8'h00;
                  ch1d_nxt = 8'h00;
                  ch2u_nxt = 8'h00;
                  ch2d_nxt = 8'h00;
                  ch4u_nxt = 8'h00;
                  ch4d_nxt = 8'h00;
                  up3_nxt  = '{p0: 8'h00, p1: 8'h00, cnt: 2'd1, evt: 1'b0};
                  dn3_nxt  = '0;
                  hst_nxt  = {ST_RST_NF, ST_RST_AVNF, ST_RST_NF, ST_RST_NF};
                  cst_nxt  = {4{ST_RST_NF}};
                end
              end else begin
                flags_nxt = flags_r & ~d[5:0];
              end
            end
            REG_CH1_DT: begin
              ch1d_nxt = d;
              cst_nxt[0][ST_AV] = 1'b1;
              hst_nxt[0][ST_NF] = 1'b0;
            end
            REG_CH2_DT: begin
              ch2d_nxt = d;
              cst_nxt[1][ST_AV] = 1'b1;
              hst_nxt[1][ST_NF] = 1'b0;
            end
            REG_CH3_DT: begin
              c3_tmp  = c3_write(dn3_r, flags_r[FL_V], d);
              dn3_nxt = c3_tmp;
              if (c3_tmp.evt) begin
                cst_nxt[2][ST_AV] = 1'b1;
                hst_nxt[2][ST_NF] = 1'b0;
              end
            end
            REG_CH4_DT: begin
              ch4d_nxt = d;
              cst_nxt[3][ST_AV] = 1'b1;
              hst_nxt[3][ST_NF] = 1'b0;
            end
            default: ;
          endcase
        end
      end

      MODE_COPRO_RD: begin
        unique case (item.reg_index)
          REG_CH1_ST: res.rd_byte = status_byte(cst_r[0], flags_r);
          REG_CH1_DT: begin
            res.rd_byte = ch1d_r;
            if (cst_r[0][ST_AV]) begin
              cst_nxt[0][ST_AV] = 1'b0;
              hst_nxt[0][ST_NF] = 1'b1;
            end
          end
          REG_CH2_ST: res.rd_byte = status_byte(cst_r[1], 6'h00);
          REG_CH2_DT: begin
            res.rd_byte = ch2d_r;
            if (cst_r[1][ST_AV]) begin
              cst_nxt[1][ST_AV] = 1'b0;
              hst_nxt[1][ST_NF] = 1'b1;
            end
          end
          REG_CH3_ST: begin
            // empty upward pair also reads as data available
            res.rd_byte = status_byte(cst_r[2], 6'h00);
            if (up3_r.cnt == 2'd0) res.rd_byte[7] = 1'b1;
          end
          REG_CH3_DT: begin
            res.rd_byte = dn3_r.p0;
            c3_tmp  = c3_read(dn3_r);
            dn3_nxt = c3_tmp;
            if (c3_tmp.evt) begin
              cst_nxt[2][ST_AV] = 1'b0;
              hst_nxt[2][ST_NF] = 1'b1;
            end
          end
          REG_CH4_ST: res.rd_byte = status_byte(cst_r[3], 6'h00);
          REG_CH4_DT: begin
            res.rd_byte = ch4d_r;
            if (cst_r[3][ST_AV]) begin
              cst_nxt[3][ST_AV] = 1'b0;
              hst_nxt[3][ST_NF] = 1'b1;
            end
          end
        endcase
      end

      MODE_COPRO_WR: begin
        unique case (item.reg_index)
          REG_CH1_DT: begin
            if (ucnt_r < CW'(DEPTH)) begin
              wr_req   = 1'b1;
              wr_addr  = tail_wrap[PW-1:0];
              wr_data  = d;
              ucnt_nxt = ucnt_r + CW'(1);
              hst_nxt[0][ST_AV] = 1'b1;
              if (ucnt_r == CW'(DEPTH - 1)) begin
                last_nxt = d;
                cst_nxt[0][ST_NF] = 1'b0;
              end
            end
          end
          REG_CH2_DT: begin
            ch2u_nxt = d;
            hst_nxt[1][ST_AV] = 1'b1;
            cst_nxt[1][ST_NF] = 1'b0;
          end
          REG_CH3_DT: begin
            c3_tmp  = c3_write(up3_r, flags_r[FL_V], d);
            up3_nxt = c3_tmp;
            if (c3_tmp.evt) begin
              hst_nxt[2][ST_AV] = 1'b1;
              cst_nxt[2][ST_NF] = 1'b0;
            end
          end
          REG_CH4_DT: begin
            ch4u_nxt = d;
            hst_nxt[3][ST_AV] = 1'b1;
            cst_nxt[3][ST_NF] = 1'b0;
          end
          default: ;
        endcase
      end
    endcase

    // levels follow the state after this access
    if (flags_nxt[FL_V]) nmi_cond = (dn3_nxt.cnt > 2'd1) || (up3_nxt.cnt == 2'd0);
    else nmi_cond = (dn3_nxt.cnt > 2'd0) || (up3_nxt.cnt == 2'd0);

    res.host_irq    = flags_nxt[FL_Q] & hst_nxt[3][ST_AV];
    res.copro_irq   = (flags_nxt[FL_I] & cst_nxt[0][ST_AV]) |
                      (flags_nxt[FL_J] & cst_nxt[3][ST_AV]);
    res.copro_nmi   = flags_nxt[FL_M] & nmi_cond;
    res.copro_reset = flags_nxt[FL_P];
  end

  assign rd_addr    = head_r;
  assign fctl.rd_en = acc;
  assign fctl.wr_en = acc & wr_req;
  assign fctl.clear = acc & clr_req;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_r <= '0;
      ucnt_r  <= '0;
      head_r  <= '0;
      last_r  <= 8'h00;
      ch1d_r  <= 8'h00;
      ch2u_r  <= 8'h00;
      ch2d_r  <= 8'h00;
      ch4u_r  <= 8'h00;
      ch4d_r  <= 8'h00;
      up3_r   <= '{p0: 8'h00, p1: 8'h00, cnt: 2'd1, evt: 1'b0};
      dn3_r   <= '0;
      hst_r   <= {ST_RST_NF, ST_RST_AVNF, ST_RST_NF, ST_RST_NF};
      cst_r   <= {4{ST_RST_NF}};
    end else if (acc) begin
      flags_r <= flags_nxt;
      ucnt_r  <= ucnt_nxt;
      head_r  <= head_nxt;
      last_r  <= last_nxt;
      ch1d_r  <= ch1d_nxt;
      ch2u_r  <= ch2u_nxt;
      ch2d_r  <= ch2d_nxt;
      ch4u_r  <= ch4u_nxt;
      ch4d_r  <= ch4d_nxt;
      up3_r   <= up3_nxt;
      dn3_r   <= dn3_nxt;
      hst_r   <= hst_nxt;
      cst_r   <= cst_nxt;
    end
  end

  a_fifo_av: assert property (@(posedge clk) disable iff (!rst_n)
    hst_r[0][ST_AV] == (ucnt_r != '0))
    else $error("host fifo available flag out of step with fill count");

  a_fifo_nf: assert property (@(posedge clk) disable iff (!rst_n)
    cst_r[0][ST_NF] == (ucnt_r != CW'(DEPTH)))
    else $error("coprocessor fifo not-full flag out of step with fill count");

  a_fifo_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    ucnt_r <= CW'(DEPTH))
    else $error("fifo fill count beyond depth");

  a_ch3_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (up3_r.cnt != 2'd3) && (dn3_r.cnt != 2'd3))
    else $error("channel 3 byte count beyond a pair");

endmodule

// File: rtl/coprocessor_link_register_fifos.sv
// coprocessor link register block: every access gives one result, registered after its transfer
// throughput one access per cycle unless stalled; state update and fifo read at input transfer
// an output register behind the ram stage lets one more access in while a result waits
// rst_n (synchronous) restores all channels, clears the flags and sets the link enabled
// fifo ram contents need no clearing pass: per-entry valid flags are cleared at once
// uses clrf_pkg, clrf_ctrl, clrf_fifo_mem
module coprocessor_link_register_fifos import clrf_pkg::*; #(
  parameter int UP_FIFO_DEPTH = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  // access input channel
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int PW = $clog2(UP_FIFO_DEPTH);

  // configuration registers
  logic       link_en_r;
  logic [7:0] dis_rval_r;
  logic       cfg_wr;

  // pipeline: ram stage then output register
  logic       s1_valid_r;
  stage_t     s1_r;
  logic       ov_r;
  out_item_t  out_r;
  logic       s1_adv;
  logic       acc;

  // controller to ram
  stage_t     res;
  fifo_ctl_t  fctl;
  logic [PW-1:0] rd_addr;
  logic [PW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    fifo_rd;

  // ---- configuration port ----
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_en_r  <= LINK_EN_RST;
      dis_rval_r <= DIS_RVAL_RST;
    end else if (cfg_wr) begin
      // register index is the word address
      unique case (paddr[2])
        CFG_LINK_EN:  link_en_r  <= pwdata[0];
        CFG_DIS_RVAL: dis_rval_r <= pwdata[7:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      CFG_LINK_EN:  prdata = {31'h0, link_en_r};
      CFG_DIS_RVAL: prdata = {24'h0, dis_rval_r};
    endcase
  end

  // ---- handshakes ----
  // ram stage moves on when the output register is free or being drained
  assign s1_adv   = s1_valid_r & (~ov_r | out_ready);
  assign in_ready = ~s1_valid_r | s1_adv;
  assign acc      = in_valid & in_ready;

  // ---- state and decode ----
  clrf_ctrl #(
    .DEPTH (UP_FIFO_DEPTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .item     (in_data),
    .link_en  (link_en_r),
    .dis_rval (dis_rval_r),
    .res      (res),
    .fctl     (fctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  // ---- channel 1 upward fifo ram ----
  // read data is held until the next transfer, so a stalled stage keeps it
  clrf_fifo_mem #(
    .DEPTH (UP_FIFO_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl     (fctl),
    .rd_addr (rd_addr),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_data (fifo_rd)
  );

  // ---- ram stage ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= res;
    end
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (s1_adv) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      // fifo head byte joins the result here
      out_r.read_data   <= s1_r.use_fifo ? fifo_rd : s1_r.rd_byte;
      out_r.host_irq    <= s1_r.host_irq;
      out_r.copro_irq   <= s1_r.copro_irq;
      out_r.copro_nmi   <= s1_r.copro_nmi;
      out_r.copro_reset <= s1_r.copro_reset;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = out_r;

endmodule
